@@ hw/rtl/pmsu_pkg.sv @@
// pmsu_pkg: shared constants for the potts metropolis site updater
// command codes, configuration register indexes, their reset values and default sizes
// no dependencies
package pmsu_pkg;

  // default lattice and spin sizes
  localparam int SIDE_X_DEFAULT    = 32;
  localparam int SIDE_Y_DEFAULT    = 32;
  localparam int SPIN_BITS_DEFAULT = 5;

  // command codes carried by an input item
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_NUM_STATES = 3'd0;
  localparam logic [2:0] CFG_THRESH_1   = 3'd1;
  localparam logic [2:0] CFG_THRESH_2   = 3'd2;
  localparam logic [2:0] CFG_THRESH_3   = 3'd3;
  localparam logic [2:0] CFG_THRESH_4   = 3'd4;

  // reset values of the configuration registers
  localparam logic [5:0]  NUM_STATES_RESET = 6'd2;
  localparam logic [15:0] THRESH_RESET     = 16'd0;

endpackage

@@ hw/rtl/potts_metropolis_site_update.sv @@
// potts_metropolis_site_update: q-state potts lattice with metropolis single-site update
// holds the lattice memory, the sweep counters and the update sequencer
// depends on pmsu_pkg
//
// usage
// - input channel (in_valid / in_stall): command, site_x, site_y, spin_value,
//   trial_random, accept_random; an item is taken when in_valid is high and
//   in_stall is low. in_stall is high during reset and while an item is being
//   worked on.
// - output channel (out_valid / out_stall): one result item per input item, held
//   in an output register until taken, so the next input item may be accepted
//   while a result still waits; a finished item waits in its last state if the
//   output register is still full.
// - configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): ready whenever
//   out of reset; write only while the block is idle.
// - an update reads through the single memory port (five reads, one per cycle,
//   then at most one write) and uses the bit-serial remainder unit that reduces
//   the trial spin modulo q, one bit a cycle over SPIN_BITS + 1 bits.
// - reset clears the sweep position to the first site, q to two and the
//   thresholds to zero; the lattice is undefined until loaded.
module potts_metropolis_site_update #(
  parameter int SIDE_X    = pmsu_pkg::SIDE_X_DEFAULT,
  parameter int SIDE_Y    = pmsu_pkg::SIDE_Y_DEFAULT,
  parameter int SPIN_BITS = pmsu_pkg::SPIN_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [4:0]         site_x,
  input  logic [4:0]         site_y,
  input  logic [4:0]         spin_value,
  input  logic [15:0]        trial_random,
  input  logic [15:0]        accept_random,
  // result item channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         spin_out,
  output logic [4:0]         x_out,
  output logic [4:0]         y_out,
  output logic               accepted,
  output logic signed [3:0]  energy_change,
  output logic               sweep_done,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NSITES = SIDE_X * SIDE_Y;
  localparam int AW     = $clog2(NSITES);
  localparam int XW     = $clog2(SIDE_X);
  localparam int YW     = $clog2(SIDE_Y);
  localparam int QW     = SPIN_BITS + 1;          // holds q up to 2^SPIN_BITS
  localparam int QMAX   = 1 << SPIN_BITS;
  localparam int PW     = QW + 16;                // (q-1) * trial_random
  localparam int STEP_W = $clog2((QW > 6) ? QW : 6);

  localparam logic [XW-1:0]     X_LAST     = XW'(SIDE_X - 1);
  localparam logic [YW-1:0]     Y_LAST     = YW'(SIDE_Y - 1);
  localparam logic [AW-1:0]     SIDE_Y_A   = AW'(SIDE_Y);
  localparam logic [STEP_W-1:0] FETCH_LAST = STEP_W'(5);
  localparam logic [STEP_W-1:0] MOD_LAST   = STEP_W'(QW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_READ,
    S_READW,
    S_FETCH,
    S_SUM,
    S_MOD,
    S_EVAL
  } state_t;

  state_t state;

  // configuration registers
  logic [5:0]  num_states;
  logic [15:0] thresh [4];

  // captured input item, coordinates already wrapped
  logic [XW-1:0]        sx;
  logic [YW-1:0]        sy;
  logic [SPIN_BITS-1:0] sval;
  logic [15:0]          rt;
  logic [15:0]          ra;

  // sweep position
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;

  // update working registers
  logic [STEP_W-1:0]    step;
  logic [SPIN_BITS-1:0] nb [4];
  logic [SPIN_BITS-1:0] old;
  logic [PW-1:0]        prod;
  logic [QW-1:0]        t_sh;
  logic [QW-1:0]        rem;

  // lattice memory
  logic [SPIN_BITS-1:0] lattice [NSITES];
  logic [SPIN_BITS-1:0] rdata;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic [SPIN_BITS-1:0] mem_wdata;

  // combinational helpers
  logic [4:0]           wx5;
  logic [4:0]           wy5;
  logic [XW-1:0]        xp;
  logic [XW-1:0]        xm;
  logic [YW-1:0]        yp;
  logic [YW-1:0]        ym;
  logic [XW-1:0]        ax;
  logic [YW-1:0]        ay;
  logic [QW-1:0]        q_eff;
  logic [QW-1:0]        shifted;
  logic [SPIN_BITS-1:0] trial;
  logic [2:0]           eo;
  logic [2:0]           en;
  logic signed [3:0]    de;
  logic                 acc;
  logic                 out_free;
  logic                 last_site;

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign out_free  = !out_valid || !out_stall;
  assign last_site = (cur_x == X_LAST) && (cur_y == Y_LAST);

  // wrap the 5-bit coordinates onto the lattice by repeated subtraction
  always_comb begin
    wx5 = site_x;
    wy5 = site_y;
    for (int i = 0; i < 8; i++) begin
      if (int'(wx5) >= SIDE_X) begin
        wx5 = wx5 - 5'(SIDE_X);
      end
      if (int'(wy5) >= SIDE_Y) begin
        wy5 = wy5 - 5'(SIDE_Y);
      end
    end
  end

  // clamp q to 2 .. 2^SPIN_BITS
  always_comb begin
    if (num_states < 6'd2) begin
      q_eff = QW'(2);
    end else if (int'(num_states) > QMAX) begin
      q_eff = QW'(QMAX);
    end else begin
      q_eff = QW'(num_states);
    end
  end

  // wrapped neighbours of the current site
  assign xp = (cur_x == X_LAST) ? '0 : cur_x + XW'(1);
  assign xm = (cur_x == '0) ? X_LAST : cur_x - XW'(1);
  assign yp = (cur_y == Y_LAST) ? '0 : cur_y + YW'(1);
  assign ym = (cur_y == '0) ? Y_LAST : cur_y - YW'(1);

  // site select for the single memory port
  always_comb begin
    ax = sx;
    ay = sy;
    case (state)
      S_FETCH: begin
        ax = cur_x;
        ay = cur_y;
        if (step == STEP_W'(0)) begin
          ax = xp;
        end else if (step == STEP_W'(1)) begin
          ax = xm;
        end else if (step == STEP_W'(2)) begin
          ay = yp;
        end else if (step == STEP_W'(3)) begin
          ay = ym;
        end
      end
      S_EVAL: begin
        ax = cur_x;
        ay = cur_y;
      end
      default: begin
        ax = sx;
        ay = sy;
      end
    endcase
  end

  // linear address, x outer and y inner
  assign mem_addr = AW'(ax) * SIDE_Y_A + AW'(ay);

  // remainder step: shift in one bit of the sum, subtract q if it fits
  assign shifted = {rem[SPIN_BITS-1:0], t_sh[QW-1]};
  assign trial   = SPIN_BITS'(rem);

  // bond counts and acceptance
  always_comb begin
    eo = '0;
    en = '0;
    for (int i = 0; i < 4; i++) begin
      eo = eo + {2'b00, (nb[i] != old)};
      en = en + {2'b00, (nb[i] != trial)};
    end
    de  = $signed({1'b0, en}) - $signed({1'b0, eo});
    acc = (de <= 4'sd0) || (ra < thresh[2'(de - 4'sd1)]);
  end

  assign mem_we    = ((state == S_LOAD) || (state == S_EVAL && acc)) && out_free;
  assign mem_wdata = (state == S_LOAD) ? sval : trial;

  // lattice memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice[mem_addr] <= mem_wdata;
    end
    rdata <= lattice[mem_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= pmsu_pkg::NUM_STATES_RESET;
      for (int i = 0; i < 4; i++) begin
        thresh[i] <= pmsu_pkg::THRESH_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmsu_pkg::CFG_NUM_STATES: num_states <= cfg_data[5:0];
        pmsu_pkg::CFG_THRESH_1:   thresh[0]  <= cfg_data;
        pmsu_pkg::CFG_THRESH_2:   thresh[1]  <= cfg_data;
        pmsu_pkg::CFG_THRESH_3:   thresh[2]  <= cfg_data;
        pmsu_pkg::CFG_THRESH_4:   thresh[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, sweep position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
      step      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sx   <= XW'(wx5);
            sy   <= YW'(wy5);
            sval <= SPIN_BITS'(spin_value);
            rt   <= trial_random;
            ra   <= accept_random;
            step <= '0;
            case (command)
              pmsu_pkg::CMD_LOAD:   state <= S_LOAD;
              pmsu_pkg::CMD_UPDATE: state <= S_FETCH;
              default:              state <= S_READ;   // unused code reads too
            endcase
          end
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            spin_out      <= 5'(sval);
            x_out         <= 5'(sx);
            y_out         <= 5'(sy);
            accepted      <= 1'b0;
            energy_change <= 4'sd0;
            sweep_done    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_READW;
        end
        S_READW: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            spin_out      <= 5'(rdata);
            x_out         <= 5'(sx);
            y_out         <= 5'(sy);
            accepted      <= 1'b0;
            energy_change <= 4'sd0;
            sweep_done    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_FETCH: begin
          // the registered read data belongs to the address of the step before
          prod <= PW'(q_eff - QW'(1)) * PW'(rt);
          if (step != STEP_W'(0) && step != FETCH_LAST) begin
            nb[2'(step - STEP_W'(1))] <= rdata;
          end
          if (step == FETCH_LAST) begin
            old   <= rdata;
            state <= S_SUM;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_SUM: begin
          t_sh  <= QW'(old) + QW'(1) + QW'(prod >> 16);
          rem   <= '0;
          step  <= '0;
          state <= S_MOD;
        end
        S_MOD: begin
          rem  <= (shifted >= q_eff) ? shifted - q_eff : shifted;
          t_sh <= t_sh << 1;
          step <= step + STEP_W'(1);
          if (step == MOD_LAST) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            spin_out      <= 5'(acc ? trial : old);
            x_out         <= 5'(cur_x);
            y_out         <= 5'(cur_y);
            accepted      <= acc;
            energy_change <= de;
            sweep_done    <= last_site;
            // y advances fastest, wrap to the first site after the last
            if (cur_y == Y_LAST) begin
              cur_y <= '0;
              cur_x <= (cur_x == X_LAST) ? '0 : cur_x + XW'(1);
            end else begin
              cur_y <= cur_y + YW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
